// File: src/ps2_sc_pkg.sv
package ps2_sc_pkg;

	// Special bytes of the keyboard stream.
	localparam logic [7:0] CODE_OVERRUN  = 8'h00;
	localparam logic [7:0] CODE_E0       = 8'hE0;
	localparam logic [7:0] CODE_E1       = 8'hE1;
	localparam logic [7:0] CODE_BREAK    = 8'hF0;
	localparam logic [7:0] CODE_SET1_ERR = 8'hFF;

	// Key codes that need special handling.
	localparam logic [7:0] CODE_PAUSE_BRK = 8'h7E;
	localparam logic [7:0] CODE_CTRL      = 8'h14;
	localparam logic [7:0] CODE_NUM_LOCK  = 8'h77;
	localparam logic [7:0] CODE_LALT      = 8'h11;
	localparam logic [7:0] CODE_LSHIFT    = 8'h12;
	localparam logic [7:0] CODE_RSHIFT    = 8'h59;
	localparam logic [7:0] CODE_LWIN      = 8'h1F;
	localparam logic [7:0] CODE_RWIN      = 8'h27;

	// Codes at or above this value fold back onto the table index.
	localparam logic [7:0] IDX_WRAP = 8'h90;

	// Lookup table columns.
	localparam logic [1:0] COL_DEFAULT = 2'd0;
	localparam logic [1:0] COL_E0      = 2'd1;
	localparam logic [1:0] COL_E1      = 2'd2;

	// Modifier mask bit positions.
	localparam int unsigned MOD_LSHIFT = 0;
	localparam int unsigned MOD_RSHIFT = 1;
	localparam int unsigned MOD_LCTRL  = 2;
	localparam int unsigned MOD_RCTRL  = 3;
	localparam int unsigned MOD_LALT   = 4;
	localparam int unsigned MOD_RALT   = 5;
	localparam int unsigned MOD_LWIN   = 6;
	localparam int unsigned MOD_RWIN   = 7;

	typedef struct packed {
		logic rel;
		logic e1;
		logic e0;
	} prefix_t;

	typedef struct packed {
		logic [7:0] set2_code;
		logic [1:0] lookup_column;
		logic       is_release;
		logic [7:0] modifier_mask;
		logic       num_lock_on;
		logic       num_led_update;
	} key_word_t;

	// Next state and result of decoding one byte.
	typedef struct packed {
		prefix_t    prefix;
		logic [7:0] mods;
		logic       num_lock;
		logic       emit;
		key_word_t  word;
	} dec_out_t;

	// Scan code set 1 to set 2 translation, indexed by the low seven bits.
	localparam logic [7:0] SET1_MAP [128] = '{
		8'h00, 8'h76, 8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36,
		8'h3d, 8'h3e, 8'h46, 8'h45, 8'h4e, 8'h55, 8'h66, 8'h0d,
		8'h15, 8'h1d, 8'h24, 8'h2d, 8'h2c, 8'h35, 8'h3c, 8'h43,
		8'h44, 8'h4d, 8'h54, 8'h5b, 8'h5a, 8'h14, 8'h1c, 8'h1b,
		8'h23, 8'h2b, 8'h34, 8'h33, 8'h3b, 8'h42, 8'h4b, 8'h4c,
		8'h52, 8'h0e, 8'h12, 8'h5d, 8'h1a, 8'h22, 8'h21, 8'h2a,
		8'h32, 8'h31, 8'h3a, 8'h41, 8'h49, 8'h4a, 8'h59, 8'h7c,
		8'h11, 8'h29, 8'h58, 8'h05, 8'h06, 8'h04, 8'h0c, 8'h03,
		8'h0b, 8'h83, 8'h0a, 8'h01, 8'h09, 8'h77, 8'h7e, 8'h6c,
		8'h75, 8'h7d, 8'h7b, 8'h6b, 8'h73, 8'h74, 8'h79, 8'h69,
		8'h72, 8'h7a, 8'h70, 8'h71, 8'h84, 8'h60, 8'h61, 8'h78,
		8'h07, 8'h0f, 8'h17, 8'h1f, 8'h27, 8'h2f, 8'h37, 8'h3f,
		8'h47, 8'h4f, 8'h56, 8'h5e, 8'h08, 8'h10, 8'h18, 8'h20,
		8'h28, 8'h30, 8'h38, 8'h40, 8'h48, 8'h50, 8'h57, 8'h6f,
		8'h13, 8'h19, 8'h39, 8'h51, 8'h53, 8'h5c, 8'h5f, 8'h62,
		8'h63, 8'h64, 8'h65, 8'h67, 8'h68, 8'h6a, 8'h6d, 8'h6e
	};

endpackage

// File: src/ps2_scancode_decoder.sv
// PS/2 keyboard scan code decoder.
// Input channel: one raw keyboard byte per word on raw_byte, moved by in_valid and
// in_ready. Output channel: one decoded key per word (set2_code, lookup_column,
// is_release, modifier_mask, num_lock_on, num_led_update), moved by out_valid and
// out_ready. Prefix bytes, overruns and the Break and Pause make bytes update the
// internal state but produce no output word.
// cfg_write_en with cfg_write_data selects set 1 input (1) or set 2 input (0); write
// it only while no word is in flight.
// A word accepted on the input is held in the input register, decoded and then held in
// the output register. Throughput is one word per cycle unless the receiver stalls;
// the state update is a single pass of table lookup and flag logic between the input
// register and the output register.
// Reset clears the prefix and modifier state, selects set 2 input and turns num lock
// on. When the receiver stalls, the output word holds; the input stage still drains
// words that produce no output, and otherwise in_ready drops until out_ready returns.
module ps2_scancode_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic       cfg_write_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] raw_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] set2_code,
	output logic [1:0] lookup_column,
	output logic       is_release,
	output logic [7:0] modifier_mask,
	output logic       num_lock_on,
	output logic       num_led_update
);

	// Configuration.
	logic translate_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Decoder state carried from key to key.
	ps2_sc_pkg::prefix_t prefix_q;
	logic [7:0]          mods_q;
	logic                num_lock_q;

	// Output register.
	logic                  out_valid_q;
	ps2_sc_pkg::key_word_t word_q;

	ps2_sc_pkg::dec_out_t dec;
	logic                 out_free;
	logic                 s1_fire;

	ps2_sc_decode u_decode (
		.translate (translate_q),
		.raw       (byte_s1),
		.prefix    (prefix_q),
		.mods      (mods_q),
		.num_lock  (num_lock_q),
		.dec       (dec)
	);

	// The stage moves on when its word needs no output slot or one is free.
	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && (out_free || !dec.emit);
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			translate_q <= 1'b0;
		end else if (cfg_write_en) begin
			translate_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= raw_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q   <= '0;
			mods_q     <= '0;
			num_lock_q <= 1'b1;
		end else if (s1_fire) begin
			prefix_q   <= dec.prefix;
			mods_q     <= dec.mods;
			num_lock_q <= dec.num_lock;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_fire && dec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_fire && dec.emit) begin
			word_q <= dec.word;
		end
	end

	assign out_valid      = out_valid_q;
	assign set2_code      = word_q.set2_code;
	assign lookup_column  = word_q.lookup_column;
	assign is_release     = word_q.is_release;
	assign modifier_mask  = word_q.modifier_mask;
	assign num_lock_on    = word_q.num_lock_on;
	assign num_led_update = word_q.num_led_update;

endmodule

// File: src/ps2_sc_decode.sv
module ps2_sc_decode (
	input  logic                 translate,
	input  logic [7:0]           raw,
	input  ps2_sc_pkg::prefix_t  prefix,
	input  logic [7:0]           mods,
	input  logic                 num_lock,
	output ps2_sc_pkg::dec_out_t dec
);

	function automatic logic [7:0] modifier_of(input logic [7:0] idx, input logic [1:0] col);
		logic [7:0] m;
		m = '0;
		if (col == ps2_sc_pkg::COL_DEFAULT) begin
			case (idx)
				ps2_sc_pkg::CODE_LSHIFT: m[ps2_sc_pkg::MOD_LSHIFT] = 1'b1;
				ps2_sc_pkg::CODE_RSHIFT: m[ps2_sc_pkg::MOD_RSHIFT] = 1'b1;
				ps2_sc_pkg::CODE_CTRL:   m[ps2_sc_pkg::MOD_LCTRL]  = 1'b1;
				ps2_sc_pkg::CODE_LALT:   m[ps2_sc_pkg::MOD_LALT]   = 1'b1;
				default:                 m = '0;
			endcase
		end else if (col == ps2_sc_pkg::COL_E0) begin
			case (idx)
				ps2_sc_pkg::CODE_CTRL: m[ps2_sc_pkg::MOD_RCTRL] = 1'b1;
				ps2_sc_pkg::CODE_LALT: m[ps2_sc_pkg::MOD_RALT]  = 1'b1;
				ps2_sc_pkg::CODE_LWIN: m[ps2_sc_pkg::MOD_LWIN]  = 1'b1;
				ps2_sc_pkg::CODE_RWIN: m[ps2_sc_pkg::MOD_RWIN]  = 1'b1;
				default:               m = '0;
			endcase
		end
		return m;
	endfunction

	logic                is_prefix_byte;
	logic                rel_in;
	logic [7:0]          code;
	logic [7:0]          idx;
	logic [1:0]          col;
	logic [7:0]          nflag;
	logic                toggle;
	logic                drop;
	ps2_sc_pkg::prefix_t pf;

	always_comb begin
		is_prefix_byte = (raw == ps2_sc_pkg::CODE_E0) || (raw == ps2_sc_pkg::CODE_E1);
		rel_in = translate && raw[7] && !is_prefix_byte;

		// Set 1 input: an error byte becomes an overrun, prefixes pass through.
		if (!translate || is_prefix_byte) begin
			code = raw;
		end else if (raw == ps2_sc_pkg::CODE_SET1_ERR) begin
			code = ps2_sc_pkg::CODE_OVERRUN;
		end else begin
			code = ps2_sc_pkg::SET1_MAP[raw[6:0]];
		end

		pf = prefix;
		pf.rel = prefix.rel | rel_in;

		idx = (code >= ps2_sc_pkg::IDX_WRAP) ? code - ps2_sc_pkg::IDX_WRAP : code;
		col = pf.e1 ? ps2_sc_pkg::COL_E1 : (pf.e0 ? ps2_sc_pkg::COL_E0 : ps2_sc_pkg::COL_DEFAULT);
		nflag = modifier_of(idx, col);
		toggle = (col == ps2_sc_pkg::COL_DEFAULT) && (idx == ps2_sc_pkg::CODE_NUM_LOCK) && !pf.rel;

		// Break and Pause make sequences leave no trace and keep the prefixes.
		drop = (pf.e0 && !pf.rel && code == ps2_sc_pkg::CODE_PAUSE_BRK) ||
			(pf.e1 && (code == ps2_sc_pkg::CODE_CTRL ||
				(code == ps2_sc_pkg::CODE_NUM_LOCK && !pf.rel)));

		dec.prefix   = pf;
		dec.mods     = mods;
		dec.num_lock = num_lock;
		dec.emit     = 1'b0;
		dec.word.set2_code      = code;
		dec.word.lookup_column  = col;
		dec.word.is_release     = pf.rel;
		dec.word.modifier_mask  = mods;
		dec.word.num_lock_on    = num_lock;
		dec.word.num_led_update = toggle;

		unique case (code)
			ps2_sc_pkg::CODE_OVERRUN: begin
				dec.prefix = '0;
				dec.mods   = '0;
			end
			ps2_sc_pkg::CODE_E0: dec.prefix.e0 = 1'b1;
			ps2_sc_pkg::CODE_E1: dec.prefix.e1 = 1'b1;
			ps2_sc_pkg::CODE_BREAK: dec.prefix.rel = 1'b1;
			default: begin
				if (!drop) begin
					dec.mods     = pf.rel ? (mods & ~nflag) : (mods | nflag);
					dec.num_lock = num_lock ^ toggle;
					dec.prefix   = '0;
					dec.emit     = 1'b1;
					dec.word.modifier_mask = dec.mods;
					dec.word.num_lock_on   = dec.num_lock;
				end
			end
		endcase
	end

endmodule

// File: src/ps2_sc_checker.sv
module ps2_sc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] set2_code,
	input logic [1:0] lookup_column,
	input logic       is_release,
	input logic       num_lock_on,
	input logic       num_led_update
);

	// A stalled output word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(set2_code) &&
			$stable(lookup_column) && $stable(is_release) &&
			$stable(num_lock_on) && $stable(num_led_update))
		else $error("output word changed while stalled");

	// Prefix and overrun bytes never appear as keys.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> set2_code != ps2_sc_pkg::CODE_OVERRUN &&
			set2_code != ps2_sc_pkg::CODE_E0 && set2_code != ps2_sc_pkg::CODE_E1 &&
			set2_code != ps2_sc_pkg::CODE_BREAK)
		else $error("prefix or overrun byte reported as a key");

	// A num lock LED update comes only from a plain num lock press.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && num_led_update |-> !is_release &&
			lookup_column == ps2_sc_pkg::COL_DEFAULT &&
			set2_code == ps2_sc_pkg::CODE_NUM_LOCK)
		else $error("LED update without num lock press");

	// Column code three is never produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lookup_column != 2'd3)
		else $error("invalid lookup column");

endmodule

bind ps2_scancode_decoder ps2_sc_checker u_ps2_sc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.set2_code      (set2_code),
	.lookup_column  (lookup_column),
	.is_release     (is_release),
	.num_lock_on    (num_lock_on),
	.num_led_update (num_led_update)
);

// File: sim/ps2_scancode_decoder_test.sv
// Testbench for the PS/2 scan code decoder.
// Raw keyboard bytes go in one word at a time over a valid/ready channel. Every
// accepted byte is also run through a predictor kept in this file. The predictor
// holds its own prefix, modifier and num lock state and its own set 1 table. When
// a byte completes a key, the decoded word that the block must emit is queued.
// A checker pops the oldest queued word for every word taken from the output
// channel and compares each field with it.
module ps2_scancode_decoder_test;

	typedef logic [7:0] byte_list_t [$];

	// Set 1 make codes translated to set 2, indexed by the low seven bits.
	localparam logic [7:0] SET1_TO_SET2 [128] = '{
		8'h00, 8'h76, 8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36,
		8'h3d, 8'h3e, 8'h46, 8'h45, 8'h4e, 8'h55, 8'h66, 8'h0d,
		8'h15, 8'h1d, 8'h24, 8'h2d, 8'h2c, 8'h35, 8'h3c, 8'h43,
		8'h44, 8'h4d, 8'h54, 8'h5b, 8'h5a, 8'h14, 8'h1c, 8'h1b,
		8'h23, 8'h2b, 8'h34, 8'h33, 8'h3b, 8'h42, 8'h4b, 8'h4c,
		8'h52, 8'h0e, 8'h12, 8'h5d, 8'h1a, 8'h22, 8'h21, 8'h2a,
		8'h32, 8'h31, 8'h3a, 8'h41, 8'h49, 8'h4a, 8'h59, 8'h7c,
		8'h11, 8'h29, 8'h58, 8'h05, 8'h06, 8'h04, 8'h0c, 8'h03,
		8'h0b, 8'h83, 8'h0a, 8'h01, 8'h09, 8'h77, 8'h7e, 8'h6c,
		8'h75, 8'h7d, 8'h7b, 8'h6b, 8'h73, 8'h74, 8'h79, 8'h69,
		8'h72, 8'h7a, 8'h70, 8'h71, 8'h84, 8'h60, 8'h61, 8'h78,
		8'h07, 8'h0f, 8'h17, 8'h1f, 8'h27, 8'h2f, 8'h37, 8'h3f,
		8'h47, 8'h4f, 8'h56, 8'h5e, 8'h08, 8'h10, 8'h18, 8'h20,
		8'h28, 8'h30, 8'h38, 8'h40, 8'h48, 8'h50, 8'h57, 8'h6f,
		8'h13, 8'h19, 8'h39, 8'h51, 8'h53, 8'h5c, 8'h5f, 8'h62,
		8'h63, 8'h64, 8'h65, 8'h67, 8'h68, 8'h6a, 8'h6d, 8'h6e
	};

	// Set 2 keys that hit the modifier, num lock and Break/Pause logic. The codes
	// at 90h and above fold back onto a modifier entry of the table.
	localparam logic [7:0] SET2_HOT [14] = '{
		8'h11, 8'h12, 8'h14, 8'h59, 8'h1F, 8'h27, 8'h77,
		8'h7E, 8'hA1, 8'hA2, 8'hA4, 8'hE9, 8'hAF, 8'hB7
	};

	// Set 1 make codes of ctrl, shifts, alt, num lock, scroll lock/break, the win
	// keys, caps lock and escape.
	localparam logic [7:0] SET1_HOT [10] = '{
		8'h1D, 8'h2A, 8'h36, 8'h38, 8'h45, 8'h46, 8'h5B, 8'h5C, 8'h3A, 8'h01
	};

	// Receiver hold-off used to fill the block up and stall its input.
	localparam int unsigned HOLD_CYCLES = 300;

	logic       clk;
	logic       arst_n;
	logic       cfg_write_en;
	logic       cfg_write_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] raw_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] set2_code;
	logic [1:0] lookup_column;
	logic       is_release;
	logic [7:0] modifier_mask;
	logic       num_lock_on;
	logic       num_led_update;

	// Predictor state: a mirror of the configuration and decoder state.
	logic                set1_mode;
	ps2_sc_pkg::prefix_t pending;
	logic [7:0]          held_mods;
	logic                num_lock;

	// Decoded words still owed by the block, oldest first.
	ps2_sc_pkg::key_word_t expected_keys [$];

	int unsigned sent_count;
	int unsigned fault_count;

	// Idling controls shared by the sender and the receiver process.
	bit tx_idle;
	bit rx_idle;
	bit hold_request;

	ps2_scancode_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.raw_byte      (raw_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.set2_code     (set2_code),
		.lookup_column (lookup_column),
		.is_release    (is_release),
		.modifier_mask (modifier_mask),
		.num_lock_on   (num_lock_on),
		.num_led_update(num_led_update)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Length of an idle stretch: mostly a few cycles, now and then a long one.
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Decodes one accepted byte against the predictor state. Returns 1 and fills
	// the word when the byte completes a key that the block must report.
	function automatic bit decode_byte(input logic [7:0] b,
		output ps2_sc_pkg::key_word_t w);
		logic [7:0] code;
		logic [7:0] idx;
		logic [1:0] col;
		logic       rel;
		logic [7:0] flag;
		logic       led;
		code = b;
		led  = 1'b0;
		flag = '0;
		w    = '0;

		// Set 1 input: bit 7 marks a release, except on the two prefix bytes.
		// FFh is the set 1 overrun and becomes the set 2 overrun code.
		if (set1_mode) begin
			if (b[7] && b != ps2_sc_pkg::CODE_E0 && b != ps2_sc_pkg::CODE_E1)
				pending.rel = 1'b1;
			if (b == ps2_sc_pkg::CODE_SET1_ERR)
				code = ps2_sc_pkg::CODE_OVERRUN;
			else if (b != ps2_sc_pkg::CODE_E0 && b != ps2_sc_pkg::CODE_E1)
				code = SET1_TO_SET2[b[6:0]];
		end

		// Overrun wipes prefixes and modifiers but keeps num lock.
		case (code)
		ps2_sc_pkg::CODE_OVERRUN: begin
			pending   = '0;
			held_mods = '0;
			return 1'b0;
		end
		ps2_sc_pkg::CODE_E0: begin
			pending.e0 = 1'b1;
			return 1'b0;
		end
		ps2_sc_pkg::CODE_E1: begin
			pending.e1 = 1'b1;
			return 1'b0;
		end
		ps2_sc_pkg::CODE_BREAK: begin
			pending.rel = 1'b1;
			return 1'b0;
		end
		default: ;
		endcase

		idx = code % ps2_sc_pkg::IDX_WRAP;
		col = pending.e1 ? ps2_sc_pkg::COL_E1 :
			(pending.e0 ? ps2_sc_pkg::COL_E0 : ps2_sc_pkg::COL_DEFAULT);
		rel = pending.rel;

		if (col == ps2_sc_pkg::COL_DEFAULT) begin
			case (idx)
			ps2_sc_pkg::CODE_LSHIFT: flag[ps2_sc_pkg::MOD_LSHIFT] = 1'b1;
			ps2_sc_pkg::CODE_RSHIFT: flag[ps2_sc_pkg::MOD_RSHIFT] = 1'b1;
			ps2_sc_pkg::CODE_CTRL:   flag[ps2_sc_pkg::MOD_LCTRL]  = 1'b1;
			ps2_sc_pkg::CODE_LALT:   flag[ps2_sc_pkg::MOD_LALT]   = 1'b1;
			default: ;
			endcase
		end else if (col == ps2_sc_pkg::COL_E0) begin
			case (idx)
			ps2_sc_pkg::CODE_CTRL: flag[ps2_sc_pkg::MOD_RCTRL] = 1'b1;
			ps2_sc_pkg::CODE_LALT: flag[ps2_sc_pkg::MOD_RALT]  = 1'b1;
			ps2_sc_pkg::CODE_LWIN: flag[ps2_sc_pkg::MOD_LWIN]  = 1'b1;
			ps2_sc_pkg::CODE_RWIN: flag[ps2_sc_pkg::MOD_RWIN]  = 1'b1;
			default: ;
			endcase
		end

		// A num lock press toggles the lock and asks for an LED rewrite.
		if (col == ps2_sc_pkg::COL_DEFAULT && idx == ps2_sc_pkg::CODE_NUM_LOCK && !rel) begin
			num_lock = ~num_lock;
			led      = 1'b1;
		end

		// Break and Pause make bytes are swallowed and leave the prefixes pending.
		if (pending.e0 && !rel && code == ps2_sc_pkg::CODE_PAUSE_BRK)
			return 1'b0;
		if (pending.e1 && (code == ps2_sc_pkg::CODE_CTRL ||
			(code == ps2_sc_pkg::CODE_NUM_LOCK && !rel)))
			return 1'b0;

		held_mods = rel ? (held_mods & ~flag) : (held_mods | flag);

		w.set2_code      = code;
		w.lookup_column  = col;
		w.is_release     = rel;
		w.modifier_mask  = held_mods;
		w.num_lock_on    = num_lock;
		w.num_led_update = led;
		pending          = '0;
		return 1'b1;
	endfunction

	// Offers one byte, after a random gap when the sender idles, and waits for
	// the handshake. Valid is left high afterwards so that a back-to-back byte
	// keeps it asserted; the next call or the caller lowers it.
	task automatic send_byte(input logic [7:0] b);
		int unsigned           gap;
		ps2_sc_pkg::key_word_t w;
		gap = (tx_idle && $urandom_range(0, 1) == 0) ? idle_span() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		if (decode_byte(b, w))
			expected_keys.push_back(w);
		sent_count++;
	endtask

	task automatic send_list(input byte_list_t list);
		foreach (list[i])
			send_byte(list[i]);
	endtask

	// Stops sending and waits until every owed word has come out. Bytes that
	// give no word may still sit in the two-stage pipeline, so a few more cycles
	// pass before the block is taken as idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_keys.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_translation(input logic on);
		settle();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= on;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		set1_mode = on;
	endtask

	// One set 2 key event: mostly a well-formed prefix/release/key sequence,
	// sometimes a full Pause sequence, sometimes a stray byte.
	task automatic send_key_set2();
		int unsigned pick;
		int unsigned pre;
		logic [7:0]  key;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			send_byte(8'($urandom_range(0, 255)));
			return;
		end
		if (pick < 25) begin
			send_list('{ps2_sc_pkg::CODE_E1, ps2_sc_pkg::CODE_CTRL,
				ps2_sc_pkg::CODE_NUM_LOCK, ps2_sc_pkg::CODE_E1,
				ps2_sc_pkg::CODE_BREAK, ps2_sc_pkg::CODE_CTRL,
				ps2_sc_pkg::CODE_BREAK, ps2_sc_pkg::CODE_NUM_LOCK});
			return;
		end
		pre = $urandom_range(0, 99);
		if (pre >= 60 && pre < 85 || pre >= 95)
			send_byte(ps2_sc_pkg::CODE_E0);
		if (pre >= 85)
			send_byte(ps2_sc_pkg::CODE_E1);
		if ($urandom_range(0, 2) == 0)
			send_byte(ps2_sc_pkg::CODE_BREAK);
		if ($urandom_range(0, 1) == 0)
			key = SET2_HOT[$urandom_range(0, 13)];
		else
			key = 8'($urandom_range(1, 255));
		send_byte(key);
	endtask

	// One set 1 key event; bit 7 of the key byte marks the release.
	task automatic send_key_set1();
		int unsigned pick;
		int unsigned pre;
		logic [7:0]  key;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_byte(8'($urandom_range(0, 255)));
			return;
		end
		if (pick < 20) begin
			send_list('{ps2_sc_pkg::CODE_E1, 8'h1D, 8'h45, ps2_sc_pkg::CODE_E1,
				8'h9D, 8'hC5});
			return;
		end
		pre = $urandom_range(0, 99);
		if (pre >= 60 && pre < 85 || pre >= 95)
			send_byte(ps2_sc_pkg::CODE_E0);
		if (pre >= 85)
			send_byte(ps2_sc_pkg::CODE_E1);
		if ($urandom_range(0, 1) == 0)
			key = SET1_HOT[$urandom_range(0, 9)];
		else
			key = 8'($urandom_range(1, 127));
		key[7] = 1'($urandom_range(0, 1));
		send_byte(key);
	endtask

	// Set 2 input, walked by hand: modifier press and release on both columns,
	// an overrun with a shift held down, num lock press and release, the Break
	// make swallowed but its release reported, the whole Pause sequence reported
	// once as a column 2 release, and stacked repeated prefixes.
	task automatic test_set2_directed();
		set_translation(1'b0);
		send_list('{ps2_sc_pkg::CODE_LSHIFT, ps2_sc_pkg::CODE_E0, ps2_sc_pkg::CODE_LALT,
			ps2_sc_pkg::CODE_E0, ps2_sc_pkg::CODE_BREAK, ps2_sc_pkg::CODE_LALT,
			ps2_sc_pkg::CODE_OVERRUN, ps2_sc_pkg::CODE_BREAK, ps2_sc_pkg::CODE_LSHIFT,
			ps2_sc_pkg::CODE_NUM_LOCK, ps2_sc_pkg::CODE_BREAK, ps2_sc_pkg::CODE_NUM_LOCK,
			ps2_sc_pkg::CODE_E0, ps2_sc_pkg::CODE_PAUSE_BRK, ps2_sc_pkg::CODE_E0,
			ps2_sc_pkg::CODE_BREAK, ps2_sc_pkg::CODE_PAUSE_BRK,
			ps2_sc_pkg::CODE_E1, ps2_sc_pkg::CODE_CTRL, ps2_sc_pkg::CODE_NUM_LOCK,
			ps2_sc_pkg::CODE_E1, ps2_sc_pkg::CODE_BREAK, ps2_sc_pkg::CODE_CTRL,
			ps2_sc_pkg::CODE_BREAK, ps2_sc_pkg::CODE_NUM_LOCK,
			ps2_sc_pkg::CODE_E0, ps2_sc_pkg::CODE_E1, ps2_sc_pkg::CODE_BREAK,
			ps2_sc_pkg::CODE_BREAK, 8'h5A, 8'hFF});
	endtask

	// Set 1 input: shift make and break, num lock, the Break key behind E0,
	// the set 1 overrun, the release of entry zero, the Pause sequence and the
	// top of the table.
	task automatic test_set1_directed();
		set_translation(1'b1);
		send_list('{8'h2A, 8'hAA, 8'h45, ps2_sc_pkg::CODE_E0, 8'h46,
			ps2_sc_pkg::CODE_SET1_ERR, 8'h80, ps2_sc_pkg::CODE_E1, 8'h1D, 8'h45,
			ps2_sc_pkg::CODE_E1, 8'h9D, 8'hC5, 8'h7F});
	endtask

	// Random traffic in one input mode. The idle settings of both sides are
	// reshuffled now and then, including stretches where neither side idles.
	task automatic test_random_traffic(input logic on, input int unsigned count);
		int unsigned stop_at;
		set_translation(on);
		stop_at = sent_count + count;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 39) == 0) begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
			end
			if (on)
				send_key_set1();
			else
				send_key_set2();
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// bytes without gaps, so the output word sits and the input must stall.
	task automatic test_output_stall();
		int unsigned stop_at;
		set_translation(1'b0);
		tx_idle      = 1'b0;
		rx_idle      = 1'b1;
		hold_request = 1'b1;
		stop_at      = sent_count + 150;
		while (sent_count < stop_at)
			send_key_set2();
		tx_idle = 1'b1;
	endtask

	// Receiver: random ready pattern, or a counted hold-off when requested.
	initial begin : receiver
		int unsigned span;
		int unsigned hold_count;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(posedge clk);
				hold_request = 1'b0;
			end else if (rx_idle && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				span = idle_span();
				repeat (span) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				span = $urandom_range(1, 8);
				repeat (span) @(posedge clk);
			end
		end
	end

	// Checker: every word taken from the output must match the oldest owed word.
	always @(posedge clk) begin : check_words
		ps2_sc_pkg::key_word_t got;
		ps2_sc_pkg::key_word_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {set2_code, lookup_column, is_release, modifier_mask,
				num_lock_on, num_led_update};
			if (expected_keys.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: unexpected word, code %h col %0d rel %0b mods %h",
						$time, got.set2_code, got.lookup_column, got.is_release,
						got.modifier_mask);
			end else begin
				want = expected_keys.pop_front();
				if (got.set2_code !== want.set2_code
					|| got.lookup_column !== want.lookup_column
					|| got.is_release !== want.is_release
					|| got.modifier_mask !== want.modifier_mask
					|| got.num_lock_on !== want.num_lock_on
					|| got.num_led_update !== want.num_led_update) begin
					fault_count++;
					if (fault_count <= 10)
						$display({"%0t: mismatch (expected/actual) code %h/%h col %0d/%0d",
							" rel %0b/%0b mods %h/%h num %0b/%0b led %0b/%0b"},
							$time, want.set2_code, got.set2_code,
							want.lookup_column, got.lookup_column,
							want.is_release, got.is_release,
							want.modifier_mask, got.modifier_mask,
							want.num_lock_on, got.num_lock_on,
							want.num_led_update, got.num_led_update);
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main
		int unsigned waited;
		// Predictor starts in the reset state of the block.
		set1_mode    = 1'b0;
		pending      = '0;
		held_mods    = '0;
		num_lock     = 1'b1;
		sent_count   = 0;
		fault_count  = 0;
		tx_idle      = 1'b1;
		rx_idle      = 1'b1;
		hold_request = 1'b0;

		arst_n         <= 1'b0;
		cfg_write_en   <= 1'b0;
		cfg_write_data <= 1'b0;
		in_valid       <= 1'b0;
		raw_byte       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_set2_directed();
		test_set1_directed();
		test_random_traffic(1'b0, 400);
		test_random_traffic(1'b1, 400);
		test_output_stall();
		test_random_traffic(1'b0, 300);
		test_random_traffic(1'b1, 300);

		// Drain: wait for the owed words with a limit, then let the pipeline empty.
		in_valid <= 1'b0;
		for (waited = 0; waited < 5000 && expected_keys.size() != 0; waited++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_keys.size() != 0) begin
			$display("%0d expected words never arrived", expected_keys.size());
			fault_count += expected_keys.size();
		end

		if (fault_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: ps2_scancode_decoder.f
src/ps2_sc_pkg.sv
src/ps2_sc_decode.sv
src/ps2_scancode_decoder.sv
src/ps2_sc_checker.sv
sim/ps2_scancode_decoder_test.sv
